// File: rtl/pvt_pkg.sv
package pvt_pkg;

	// Fixed field widths.
	localparam int unsigned COORD_W = 24;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned PIXEL_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE = 2'd3;

	// Default screen size.
	localparam int unsigned SCREEN_WIDTH_DEF = 640;
	localparam int unsigned SCREEN_HEIGHT_DEF = 480;

	// Divider: quotient bits resolved, one per stage, and its total latency.
	localparam int unsigned DIV_QW = 17;
	localparam int unsigned DIV_LAT = DIV_QW + 2;

	// Quarter-wave sine samples, full scale 65536.
	function automatic logic [16:0] sine_tbl(input logic [5:0] k);
		logic [16:0] r;
		case (k)
			6'd0: r = 17'd0;
			6'd1: r = 17'd3216;
			6'd2: r = 17'd6424;
			6'd3: r = 17'd9616;
			6'd4: r = 17'd12785;
			6'd5: r = 17'd15924;
			6'd6: r = 17'd19024;
			6'd7: r = 17'd22078;
			6'd8: r = 17'd25080;
			6'd9: r = 17'd28020;
			6'd10: r = 17'd30893;
			6'd11: r = 17'd33692;
			6'd12: r = 17'd36410;
			6'd13: r = 17'd39040;
			6'd14: r = 17'd41576;
			6'd15: r = 17'd44011;
			6'd16: r = 17'd46341;
			6'd17: r = 17'd48559;
			6'd18: r = 17'd50660;
			6'd19: r = 17'd52639;
			6'd20: r = 17'd54491;
			6'd21: r = 17'd56212;
			6'd22: r = 17'd57798;
			6'd23: r = 17'd59244;
			6'd24: r = 17'd60547;
			6'd25: r = 17'd61705;
			6'd26: r = 17'd62714;
			6'd27: r = 17'd63572;
			6'd28: r = 17'd64277;
			6'd29: r = 17'd64827;
			6'd30: r = 17'd65220;
			6'd31: r = 17'd65457;
			6'd32: r = 17'd65536;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// Interpolated sine of a binary angle, signed Q1.16.
	function automatic logic signed [17:0] sine_of(input logic [ANGLE_W-1:0] a);
		logic [1:0] quad;
		logic [14:0] ww;
		logic [5:0] idx;
		logic [8:0] frac;
		logic [16:0] t0;
		logic [16:0] t1;
		logic [25:0] ip;
		logic [16:0] mag;
		quad = a[15:14];
		ww = quad[0] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
		idx = ww[14:9];
		frac = ww[8:0];
		t0 = sine_tbl(idx);
		t1 = sine_tbl(idx + 6'd1);
		ip = 26'(t1 - t0) * 26'(frac) + 26'd256;
		if (idx >= 6'd32) begin
			mag = 17'd65536;
		end else begin
			mag = t0 + 17'(ip >> 9);
		end
		return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// Clamp a wide signed value to the Q7.16 range.
	function automatic logic signed [COORD_W-1:0] sat24(input logic signed [42:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 43'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -43'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = COORD_W'(v);
		end
		return r;
	endfunction

endpackage

// File: rtl/pvt_div.sv
module pvt_div #(
	parameter int unsigned NW = 36,
	parameter int unsigned DW = 25
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic        [DW-1:0] den,
	output logic signed [15:0]   quo
);

	localparam int unsigned QW = pvt_pkg::DIV_QW;
	localparam int unsigned CW = NW + DW + QW;

	logic [NW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] q_s [QW+1];
	logic          neg_s [QW+1];
	logic          ovf_s [QW+1];
	logic [NW-1:0] mag;

	// Magnitude of the numerator; the negated most negative value reads right unsigned.
	assign mag = num[NW-1] ? NW'(-num) : NW'(num);

	// Entry stage: split sign, flag quotients beyond the resolved bits.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= mag;
			den_s[0] <= den;
			q_s[0] <= '0;
			neg_s[0] <= num[NW-1];
			ovf_s[0] <= CW'(mag) >= (CW'(den) << QW);
		end
	end

	// One restoring step per stage, most significant quotient bit first.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [CW-1:0] trial;
		logic          ge;
		assign trial = CW'(den_s[k]) << (QW - 1 - k);
		assign ge = CW'(rem_s[k]) >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? NW'(CW'(rem_s[k]) - trial) : rem_s[k];
				den_s[k+1] <= den_s[k];
				q_s[k+1] <= {q_s[k][QW-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// Apply the sign and clamp to the 16 bit pixel range.
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QW]) begin
				if (ovf_s[QW] || q_s[QW] > QW'(32768)) begin
					quo <= 16'sh8000;
				end else begin
					quo <= 16'(-$signed({1'b0, q_s[QW]}));
				end
			end else begin
				if (ovf_s[QW] || q_s[QW] > QW'(32767)) begin
					quo <= 16'sh7FFF;
				end else begin
					quo <= 16'(q_s[QW]);
				end
			end
		end
	end

endmodule

// File: rtl/perspective_vertex_transform.sv
// Perspective vertex transform.
// Input channel: in_valid/in_ready move one word holding point_x, point_y and
// point_z (signed Q7.16). Output channel: out_valid/out_ready move one word with
// pixel_x, pixel_y, view_depth and behind_camera for each input word, in order.
// The point is offset by the camera registers, rotated about the vertical axis,
// and projected to screen coordinates by two pipelined restoring dividers.
// One word is accepted every cycle while the output side takes words. The
// divider stages, one quotient bit each, set the depth of the pipeline.
// A stalled receiver freezes the whole pipeline: in_ready follows out_ready
// while a result is waiting, so nothing is lost or repeated.
// Configuration: cfg_we, cfg_index and cfg_data write one register per cycle;
// write only while the pipeline is empty. The sine and cosine of the angle are
// registered in the cycle after the angle is written.
// Reset clears all configuration registers and empties the pipeline.
module perspective_vertex_transform #(
	parameter int unsigned SCREEN_WIDTH = pvt_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = pvt_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic signed [23:0] view_depth,
	output logic               behind_camera
);

	localparam int unsigned DL = pvt_pkg::DIV_LAT;
	localparam int unsigned NST = 4 + DL;
	localparam int unsigned WW = $clog2(SCREEN_WIDTH + 1);
	localparam int unsigned HW = $clog2(SCREEN_HEIGHT + 1);
	localparam int unsigned NXW = 26 + WW;
	localparam int unsigned NYW = 26 + HW;
	localparam int unsigned DW = 25;

	logic signed [23:0] off_x_q;
	logic signed [23:0] off_y_q;
	logic signed [23:0] off_z_q;
	logic [15:0]        angle_q;
	logic signed [17:0] sin_q;
	logic signed [17:0] cos_q;

	logic               en;
	logic [NST:1]       vld_q;

	logic signed [23:0] x_s1, y_s1, z_s1;
	logic signed [41:0] xc_s2, zs_s2, xs_s2, zc_s2;
	logic signed [23:0] y_s2;
	logic signed [23:0] xr_s3, zr_s3, y_s3;
	logic signed [NXW-1:0] nx_s4;
	logic signed [NYW-1:0] ny_s4;
	logic [DW-1:0]      den_s4;
	logic signed [23:0] zr_d [DL+1];
	logic               bh_d [DL+1];
	logic signed [15:0] qx, qy;

	logic signed [42:0] rx, rz;
	logic signed [24:0] sx, sy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			angle_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pvt_pkg::REG_OFF_X: off_x_q <= cfg_data;
				pvt_pkg::REG_OFF_Y: off_y_q <= cfg_data;
				pvt_pkg::REG_OFF_Z: off_z_q <= cfg_data;
				pvt_pkg::REG_ANGLE: angle_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sine and cosine of the current angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_q <= '0;
			cos_q <= 18'sd65536;
		end else begin
			sin_q <= pvt_pkg::sine_of(angle_q);
			cos_q <= pvt_pkg::sine_of(angle_q + 16'd16384);
		end
	end

	// The whole pipeline advances unless a finished word is held.
	assign en = !vld_q[NST] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], in_valid};
		end
	end

	// Stage 1: camera offset with saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= pvt_pkg::sat24(43'(point_x) + 43'(off_x_q));
			y_s1 <= pvt_pkg::sat24(43'(point_y) + 43'(off_y_q));
			z_s1 <= pvt_pkg::sat24(43'(point_z) + 43'(off_z_q));
		end
	end

	// Stage 2: rotation products.
	always_ff @(posedge clk) begin
		if (en) begin
			xc_s2 <= 42'(x_s1) * 42'(cos_q);
			zs_s2 <= 42'(z_s1) * 42'(sin_q);
			xs_s2 <= 42'(x_s1) * 42'(sin_q);
			zc_s2 <= 42'(z_s1) * 42'(cos_q);
			y_s2 <= y_s1;
		end
	end

	// Stage 3: sum, round half up to Q7.16, saturate.
	assign rx = (43'(xc_s2) - 43'(zs_s2) + 43'sd32768) >>> 16;
	assign rz = (43'(xs_s2) + 43'(zc_s2) + 43'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s3 <= pvt_pkg::sat24(rx);
			zr_s3 <= pvt_pkg::sat24(rz);
			y_s3 <= y_s2;
		end
	end

	// Stage 4: numerators scaled by the screen size, denominator twice the depth (one when the depth is not positive).
	assign sx = 25'(xr_s3) + 25'(zr_s3);
	assign sy = 25'(zr_s3) - 25'(y_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4 <= NXW'(sx) * $signed(NXW'(SCREEN_WIDTH));
			ny_s4 <= NYW'(sy) * $signed(NYW'(SCREEN_HEIGHT));
			den_s4 <= (zr_s3 > 24'sd0) ? {zr_s3, 1'b0} : DW'(1);
			zr_d[0] <= zr_s3;
			bh_d[0] <= !(zr_s3 > 24'sd0);
		end
	end

	// Depth and flag ride alongside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 1; i <= DL; i++) begin
				zr_d[i] <= zr_d[i-1];
				bh_d[i] <= bh_d[i-1];
			end
		end
	end

	pvt_div #(.NW(NXW), .DW(DW)) u_div_x (
		.clk(clk), .en(en), .num(nx_s4), .den(den_s4), .quo(qx)
	);

	pvt_div #(.NW(NYW), .DW(DW)) u_div_y (
		.clk(clk), .en(en), .num(ny_s4), .den(den_s4), .quo(qy)
	);

	// Output word; pixels are zero behind the camera.
	assign out_valid = vld_q[NST];
	assign pixel_x = bh_d[DL] ? 16'sd0 : qx;
	assign pixel_y = bh_d[DL] ? 16'sd0 : qy;
	assign view_depth = zr_d[DL];
	assign behind_camera = bh_d[DL];

endmodule
